// File: src/hashed_value_noise_2d_defines.svh
// Assertion macros shared by the noise block.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef HASHED_VALUE_NOISE_2D_DEFINES_SVH
`define HASHED_VALUE_NOISE_2D_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define HVN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HVN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HVN_ASSERT(lbl, prop, msg)
`define HVN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/hvn_pkg.sv
// Shared types and constants of the hashed value noise block.
// No dependencies.
`timescale 1ns / 1ps

package hvn_pkg;

    localparam int POS_W  = 48;
    localparam int HASH_W = 64;
    localparam int HALF_W = 32;
    localparam int VAL_W  = 16;

    // splitmix64 finalizer
    localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;
    localparam int MIX_LAT = 4;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [HASH_W-1:0]       hash_t;
    typedef logic [HALF_W-1:0]       half_t;
    typedef logic [VAL_W-1:0]        value_t;

endpackage

// File: src/hvn_in_if.sv
// Input channel: one sample point per transfer.
// Depends on hvn_pkg.
`timescale 1ns / 1ps

interface hvn_in_if;
    logic          valid;
    logic          ready;
    hvn_pkg::pos_t x_pos;
    hvn_pkg::pos_t y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

// File: src/hvn_out_if.sv
// Output channel: one noise value per transfer.
// Depends on hvn_pkg.
`timescale 1ns / 1ps

interface hvn_out_if;
    logic            valid;
    logic            ready;
    hvn_pkg::value_t noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// File: src/hvn_mix.sv
// splitmix64 finalizer, four register stages, 64-bit products cut into 32x32 parts.
// Depends on hvn_pkg.
`timescale 1ns / 1ps

module hvn_mix (
    input  logic           clk,
    input  logic           en,
    input  hvn_pkg::hash_t din,
    output hvn_pkg::hash_t dout
);

    localparam int H = hvn_pkg::HALF_W;
    localparam int W = hvn_pkg::HASH_W;

    localparam hvn_pkg::half_t A_LO = hvn_pkg::MIX_MUL_A[H-1:0];
    localparam hvn_pkg::half_t A_HI = hvn_pkg::MIX_MUL_A[W-1:H];
    localparam hvn_pkg::half_t B_LO = hvn_pkg::MIX_MUL_B[H-1:0];
    localparam hvn_pkg::half_t B_HI = hvn_pkg::MIX_MUL_B[W-1:H];

    hvn_pkg::hash_t t;
    hvn_pkg::hash_t pa_lo_next, pa_lo_reg;
    hvn_pkg::half_t pa_x_next, pa_x_reg, pa_y_next, pa_y_reg;
    hvn_pkg::hash_t m_next, m_reg;
    hvn_pkg::hash_t u;
    hvn_pkg::hash_t pb_lo_next, pb_lo_reg;
    hvn_pkg::half_t pb_x_next, pb_x_reg, pb_y_next, pb_y_reg;
    hvn_pkg::hash_t w;
    hvn_pkg::hash_t dout_next, dout_reg;

    always_comb
    begin
        // first multiply, low 64 bits only
        t          = din ^ (din >> hvn_pkg::MIX_SH1);
        pa_lo_next = t[H-1:0] * A_LO;
        pa_x_next  = H'(t[W-1:H] * A_LO);
        pa_y_next  = H'(t[H-1:0] * A_HI);
        m_next     = pa_lo_reg + {hvn_pkg::half_t'(pa_x_reg + pa_y_reg), {H{1'b0}}};
        // second multiply
        u          = m_reg ^ (m_reg >> hvn_pkg::MIX_SH2);
        pb_lo_next = u[H-1:0] * B_LO;
        pb_x_next  = H'(u[W-1:H] * B_LO);
        pb_y_next  = H'(u[H-1:0] * B_HI);
        w          = pb_lo_reg + {hvn_pkg::half_t'(pb_x_reg + pb_y_reg), {H{1'b0}}};
        dout_next  = w ^ (w >> hvn_pkg::MIX_SH3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_lo_reg <= pa_lo_next;
            pa_x_reg  <= pa_x_next;
            pa_y_reg  <= pa_y_next;
            m_reg     <= m_next;
            pb_lo_reg <= pb_lo_next;
            pb_x_reg  <= pb_x_next;
            pb_y_reg  <= pb_y_next;
            dout_reg  <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// File: src/hashed_value_noise_2d.sv
// Top level of the seeded 2D value noise pipeline.
// Depends on hvn_pkg, hvn_in_if, hvn_out_if, hvn_mix and the assertion macro header.
`timescale 1ns / 1ps

// Seeded 2D value noise. A point in two's complement with FRAC_BITS fraction
// bits is taken per transfer on sample_in; the matching noise value (0..65535,
// 65535 meaning 1.0) leaves on noise_out in the same order. The block takes one
// sample every cycle unless noise_out stalls. Each sample passes through one stage
// to floor the point and add the seed, two 4-stage splitmix64 finalizers in series
// (the y hash, then x xor that hash), and two blend stages. Each finalizer
// multiply is split into 32x32 partial products, which sets the stage count.
// The whole pipe moves together: it advances whenever the output register is
// empty or its value is being taken, so a stall on noise_out freezes every
// stage and nothing is lost or repeated. The seed is written through cfg_we /
// cfg_wdata and must only change while no sample is in flight.

`include "hashed_value_noise_2d_defines.svh"

module hashed_value_noise_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  hvn_pkg::hash_t cfg_wdata,
    hvn_in_if.sink         sample_in,
    hvn_out_if.source      noise_out
);

    localparam int F     = FRAC_BITS;
    localparam int VW    = hvn_pkg::VAL_W;
    localparam int Y_OUT = 1 + hvn_pkg::MIX_LAT;      // y hash ready
    localparam int X_OUT = Y_OUT + hvn_pkg::MIX_LAT;  // corner hashes ready
    localparam int ROW   = X_OUT + 1;                 // row blends
    localparam int NSTG  = ROW + 1;                   // output register

    localparam logic [F:0]   ONE       = (F+1)'(1) << F;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

    // Bilinear step: (a*(1-t) + b*t) >> F, truncating.
    function automatic hvn_pkg::value_t lerp(hvn_pkg::value_t a, hvn_pkg::value_t b,
                                             logic [F-1:0] t);
        logic [F:0]    omt;
        logic [VW+F:0] acc;
        omt = ONE - (F+1)'(t);
        acc = a * omt + b * t;
        return acc[VW+F-1:F];
    endfunction

    // ---- control ----
    logic              adv;
    logic [NSTG:1]     valid_reg;
    hvn_pkg::hash_t    seed_reg;

    // ---- stage 1: floor, fraction, seed add ----
    hvn_pkg::hash_t    xw, yw, iy;
    hvn_pkg::hash_t    ix_next, cy0_next, cy1_next;
    hvn_pkg::hash_t    cy0_reg, cy1_reg;
    hvn_pkg::hash_t    ix_reg  [1:Y_OUT];
    hvn_pkg::hash_t    ix1_next;
    hvn_pkg::hash_t    ix1_reg [2:Y_OUT];
    logic [F-1:0]      fx_reg [1:2];
    logic [F-1:0]      fy_reg [1:2];

    // ---- easing ----
    logic [2*F-1:0]    fxsq, fysq;
    logic [F-1:0]      f2x_next, f2y_next, f2x_reg, f2y_reg;
    logic [F+1:0]      kx, ky;
    logic [2*F+1:0]    ex, ey;
    logic [F-1:0]      sx_next, sy_next;
    logic [F-1:0]      sx_reg [3:X_OUT];
    logic [F-1:0]      sy_reg [3:ROW];

    // ---- hashing ----
    hvn_pkg::hash_t    hy0, hy1;
    hvn_pkg::hash_t    h00, h10, h01, h11;

    // ---- blend ----
    hvn_pkg::value_t   r0_next, r1_next, r0_reg, r1_reg;
    hvn_pkg::value_t   noise_next, noise_reg;

    // Pipe moves when the output slot is free or being emptied.
    assign adv             = !valid_reg[NSTG] || noise_out.ready;
    assign sample_in.ready = adv;
    assign noise_out.valid       = valid_reg[NSTG];
    assign noise_out.noise_value = noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seed_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= {valid_reg[NSTG-1:1], sample_in.valid};
            end
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        // Sign-extend to 64 bits; arithmetic shift gives the floor.
        xw       = {{(hvn_pkg::HASH_W-hvn_pkg::POS_W){sample_in.x_pos[hvn_pkg::POS_W-1]}},
                    sample_in.x_pos};
        yw       = {{(hvn_pkg::HASH_W-hvn_pkg::POS_W){sample_in.y_pos[hvn_pkg::POS_W-1]}},
                    sample_in.y_pos};
        ix_next  = hvn_pkg::hash_t'($signed(xw) >>> F);
        iy       = hvn_pkg::hash_t'($signed(yw) >>> F);
        cy0_next = iy + seed_reg;
        cy1_next = iy + seed_reg + hvn_pkg::hash_t'(1);

        ix1_next = ix_reg[1] + hvn_pkg::hash_t'(1);

        // smoothstep: f2 = f*f >> F, s = f2*(3 - 2f) >> F
        fxsq     = fx_reg[1] * fx_reg[1];
        fysq     = fy_reg[1] * fy_reg[1];
        f2x_next = fxsq[2*F-1:F];
        f2y_next = fysq[2*F-1:F];
        kx       = THREE_ONE - (F+2)'({fx_reg[2], 1'b0});
        ky       = THREE_ONE - (F+2)'({fy_reg[2], 1'b0});
        ex       = f2x_reg * kx;
        ey       = f2y_reg * ky;
        sx_next  = ex[2*F-1:F];
        sy_next  = ey[2*F-1:F];

        // low 16 bits of each corner hash are the lattice values
        r0_next    = lerp(h00[VW-1:0], h10[VW-1:0], sx_reg[X_OUT]);
        r1_next    = lerp(h01[VW-1:0], h11[VW-1:0], sx_reg[X_OUT]);
        noise_next = lerp(r0_reg, r1_reg, sy_reg[ROW]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ix_reg[1]  <= ix_next;
            cy0_reg    <= cy0_next;
            cy1_reg    <= cy1_next;
            fx_reg[1]  <= sample_in.x_pos[F-1:0];
            fy_reg[1]  <= sample_in.y_pos[F-1:0];
            fx_reg[2]  <= fx_reg[1];
            fy_reg[2]  <= fy_reg[1];
            f2x_reg    <= f2x_next;
            f2y_reg    <= f2y_next;
            ix1_reg[2] <= ix1_next;
            for (int k = 2; k <= Y_OUT; k++)
            begin
                ix_reg[k] <= ix_reg[k-1];
            end
            for (int k = 3; k <= Y_OUT; k++)
            begin
                ix1_reg[k] <= ix1_reg[k-1];
            end
            sx_reg[3] <= sx_next;
            sy_reg[3] <= sy_next;
            for (int k = 4; k <= X_OUT; k++)
            begin
                sx_reg[k] <= sx_reg[k-1];
            end
            for (int k = 4; k <= ROW; k++)
            begin
                sy_reg[k] <= sy_reg[k-1];
            end
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            noise_reg <= noise_next;
        end
    end

    // y hashes: mix(cy + seed) for both rows
    hvn_mix u_mix_y0 (.clk(clk), .en(adv), .din(cy0_reg), .dout(hy0));
    hvn_mix u_mix_y1 (.clk(clk), .en(adv), .din(cy1_reg), .dout(hy1));

    // corner hashes: mix(cx ^ hy)
    hvn_mix u_mix_00 (.clk(clk), .en(adv), .din(ix_reg[Y_OUT]  ^ hy0), .dout(h00));
    hvn_mix u_mix_10 (.clk(clk), .en(adv), .din(ix1_reg[Y_OUT] ^ hy0), .dout(h10));
    hvn_mix u_mix_01 (.clk(clk), .en(adv), .din(ix_reg[Y_OUT]  ^ hy1), .dout(h01));
    hvn_mix u_mix_11 (.clk(clk), .en(adv), .din(ix1_reg[Y_OUT] ^ hy1), .dout(h11));

    // a held result must block new samples
    `HVN_ASSERT(a_stall_blocks_input, noise_out.valid && !noise_out.ready |-> !sample_in.ready, "input taken while output stalled")
    // a frozen pipe keeps its occupancy
    `HVN_ASSERT(a_frozen_valids, !adv |=> $stable(valid_reg), "valid bits moved during stall")
    // nothing offered while in reset
    `HVN_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !noise_out.valid, "output valid during reset")

endmodule

// File: dv/tb_hashed_value_noise_2d.sv
// Self-checking testbench for hashed_value_noise_2d: 2D value noise against a local predictor.
// Depends on hvn_pkg, hvn_in_if, hvn_out_if and the block itself.
`timescale 1ns / 1ps

module tb_hashed_value_noise_2d;

    localparam int             FRAC          = 16;
    localparam hvn_pkg::hash_t ONE           = hvn_pkg::hash_t'(1) << FRAC;
    localparam int             GAP_MAX       = 18;
    localparam int             HOLD_CYCLES   = 300;  // long receiver hold-off for the pressure test
    localparam int             RANDOM_PHASES = 8;
    localparam int             PHASE_POINTS  = 88;
    localparam int             TAIL_CYCLES   = 30;   // pipe is 11 deep; watch a little longer
    localparam int             CYCLE_LIMIT   = 400000;

    localparam hvn_pkg::pos_t POS_MAX = {1'b0, {(hvn_pkg::POS_W-1){1'b1}}};
    localparam hvn_pkg::pos_t POS_MIN = {1'b1, {(hvn_pkg::POS_W-1){1'b0}}};

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    hvn_pkg::hash_t cfg_wdata;

    hvn_in_if  sample_if ();
    hvn_out_if result_if ();

    hashed_value_noise_2d #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_in (sample_if),
        .noise_out (result_if)
    );

    // Predictor state: the seed as last written, and the noise values still owed.
    hvn_pkg::hash_t  seed_shadow = '0;
    hvn_pkg::value_t noise_expected[$];

    int  error_count     = 0;
    int  results_checked = 0;
    int  seeds_written   = 0;
    int  cycle_count     = 0;
    bit  sender_calm     = 1'b0;   // no gaps between offered points
    bit  receiver_calm   = 1'b0;   // no stalls on the result side
    bit  hold_request    = 1'b0;   // ask the receiver for one long hold-off

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // splitmix64 finalizer; products wrap at 64 bits
    function automatic hvn_pkg::hash_t splitmix_finalize(input hvn_pkg::hash_t v);
        v = (v ^ (v >> hvn_pkg::MIX_SH1)) * hvn_pkg::MIX_MUL_A;
        v = (v ^ (v >> hvn_pkg::MIX_SH2)) * hvn_pkg::MIX_MUL_B;
        return v ^ (v >> hvn_pkg::MIX_SH3);
    endfunction

    // Low 16 bits of mix(cx ^ mix(cy + seed)); cy + seed wraps modulo 2^64
    function automatic hvn_pkg::hash_t lattice_value(input hvn_pkg::hash_t cx,
                                                     input hvn_pkg::hash_t cy,
                                                     input hvn_pkg::hash_t sd);
        return splitmix_finalize(cx ^ splitmix_finalize(cy + sd)) & hvn_pkg::hash_t'(16'hFFFF);
    endfunction

    // Smoothstep 3f^2 - 2f^3 with truncation after each product
    function automatic hvn_pkg::hash_t smoothstep_fixed(input hvn_pkg::hash_t f);
        hvn_pkg::hash_t f2;
        f2 = (f * f) >> FRAC;
        return (f2 * (3 * ONE - 2 * f)) >> FRAC;
    endfunction

    function automatic hvn_pkg::hash_t blend(input hvn_pkg::hash_t a, input hvn_pkg::hash_t b,
                                             input hvn_pkg::hash_t t);
        return (a * (ONE - t) + b * t) >> FRAC;
    endfunction

    function automatic hvn_pkg::value_t noise_of(input hvn_pkg::pos_t x, input hvn_pkg::pos_t y,
                                                 input hvn_pkg::hash_t sd);
        hvn_pkg::hash_t xw, yw, ix, iy, sx, sy, r0, r1;
        xw = {{(hvn_pkg::HASH_W-hvn_pkg::POS_W){x[hvn_pkg::POS_W-1]}}, x};
        yw = {{(hvn_pkg::HASH_W-hvn_pkg::POS_W){y[hvn_pkg::POS_W-1]}}, y};
        // arithmetic shift gives the floor, towards minus infinity
        ix = hvn_pkg::hash_t'($signed(xw) >>> FRAC);
        iy = hvn_pkg::hash_t'($signed(yw) >>> FRAC);
        sx = smoothstep_fixed(xw & (ONE - 1));
        sy = smoothstep_fixed(yw & (ONE - 1));
        r0 = blend(lattice_value(ix, iy, sd), lattice_value(ix + 1, iy, sd), sx);
        r1 = blend(lattice_value(ix, iy + 1, sd), lattice_value(ix + 1, iy + 1, sd), sx);
        return hvn_pkg::value_t'(blend(r0, r1, sy));
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Every accepted point owes one noise value, computed with the current seed.
    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
        begin
            noise_expected.insert(noise_expected.size(),
                                  noise_of(sample_if.x_pos, sample_if.y_pos, seed_shadow));
        end
    end

    // Compare each result transfer against the oldest outstanding value.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (noise_expected.size() == 0)
            begin
                $error("noise_value: expected none, actual %0d", result_if.noise_value);
                error_count++;
            end
            else
            begin
                hvn_pkg::value_t want;
                want = noise_expected.pop_front();
                results_checked++;
                if (result_if.noise_value !== want)
                begin
                    $error("noise_value: expected %0d, actual %0d", want, result_if.noise_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("hashed_value_noise_2d regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls per transfer, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = receiver_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Shared sender and phase helpers
    // ------------------------------------------------------------------

    // Offer one point; returns at the edge where it is taken, valid still high.
    task automatic send_point(input hvn_pkg::pos_t x, input hvn_pkg::pos_t y);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.x_pos <= x;
        sample_if.y_pos <= y;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed value has come back.
    // One edge first, so the last transfer is already on the queue.
    task automatic settle_phase();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (noise_expected.size() != 0)
            @(posedge clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_seed(input hvn_pkg::hash_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_shadow = value;
        seeds_written++;
    endtask

    // Mix of full-range, near-origin, fraction-edge and near-extreme coordinates
    function automatic hvn_pkg::pos_t random_pos();
        int            near;
        hvn_pkg::pos_t p;
        case ($urandom_range(0, 3))
            0:
            begin
                p = hvn_pkg::pos_t'({$urandom(), $urandom()});
            end
            1:
            begin
                near = $urandom_range(0, 2097151) - 1048576;   // about -16..16 lattice cells
                p    = hvn_pkg::pos_t'(near);
            end
            2:
            begin
                p = hvn_pkg::pos_t'({$urandom(), $urandom()});
                case ($urandom_range(0, 3))
                    0: p[FRAC-1:0] = '0;
                    1: p[FRAC-1:0] = '1;
                    2: p[FRAC-1:0] = 16'h0001;
                    default: p[FRAC-1:0] = 16'h8000;
                endcase
            end
            default:
            begin
                p = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                p[FRAC+3:0] = (FRAC+4)'($urandom());
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, lattice points, fraction edges and the floor of negatives
    task automatic test_directed_points();
        write_seed('0);
        send_point('0, '0);
        send_point(POS_MAX, POS_MAX);
        send_point(POS_MIN, POS_MIN);
        send_point(POS_MAX, POS_MIN);
        send_point(POS_MIN, POS_MAX);
        send_point(hvn_pkg::pos_t'(-1), '0);   // just below zero: corner -1, +1 wraps to 0
        send_point('0, hvn_pkg::pos_t'(-1));
        send_point(hvn_pkg::pos_t'(-1), hvn_pkg::pos_t'(-1));
        send_point(hvn_pkg::pos_t'(ONE), hvn_pkg::pos_t'(ONE)); // exact lattice point
        send_point(hvn_pkg::pos_t'(-65536), hvn_pkg::pos_t'(-131072));
        send_point(hvn_pkg::pos_t'(16'hFFFF), hvn_pkg::pos_t'(16'h0001));
        send_point(hvn_pkg::pos_t'(16'h8000), hvn_pkg::pos_t'(16'h8000));
        send_point(hvn_pkg::pos_t'(-32768), hvn_pkg::pos_t'(98304));
        send_point(POS_MAX, '0);              // largest corner, x + 1 crosses into 2^31
        send_point('0, POS_MIN);
        settle_phase();
    endtask

    // Seeds at the ends of the range; all-ones makes cy + seed wrap
    task automatic test_seed_extremes();
        hvn_pkg::hash_t seeds[3];
        seeds[0] = '1;
        seeds[1] = hvn_pkg::hash_t'(1) << (hvn_pkg::HASH_W - 1);
        seeds[2] = hvn_pkg::hash_t'(1);
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            send_point('0, '0);
            send_point(hvn_pkg::pos_t'(-1), hvn_pkg::pos_t'(-1));
            send_point(POS_MIN, POS_MAX);
            send_point(POS_MAX, hvn_pkg::pos_t'(-65536));
            settle_phase();
        end
    endtask

    // Receiver holds off for a long stretch while points keep coming back to back,
    // so the pipe fills and pushes back on the input.
    task automatic test_output_hold();
        write_seed({$urandom(), $urandom()});
        sender_calm  = 1'b1;
        hold_request = 1'b1;
        repeat (80) send_point(random_pos(), random_pos());
        settle_phase();
        sender_calm = 1'b0;
    endtask

    // Random points over several seeds, alternating busy and relaxed handshakes
    task automatic test_random_points();
        hvn_pkg::hash_t sd;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       sd = '0;
                1:       sd = '1;
                default: sd = {$urandom(), $urandom()};
            endcase
            write_seed(sd);
            sender_calm   = (ph % 3 == 1);
            receiver_calm = (ph % 4 == 2);
            repeat (PHASE_POINTS) send_point(random_pos(), random_pos());
            settle_phase();
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        sample_if.valid   <= 1'b0;
        sample_if.x_pos   <= '0;
        sample_if.y_pos   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_seed_extremes();
        test_output_hold();
        test_random_points();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d noise values over %0d seed writes,", results_checked, seeds_written);
        $display("with random gaps, stalls and a %0d-cycle output hold.", HOLD_CYCLES);
        if (error_count == 0)
            $display("hashed_value_noise_2d regression: pass");
        else
            $display("hashed_value_noise_2d regression: fail");
        $finish;
    end

endmodule
